// File: hdl/iwdg_pkg.sv
`default_nettype none

package iwdg_pkg;

  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned INDEX_BITS = 3;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned CODE_BITS  = 3;
  localparam int unsigned PCOUNT_BITS = 8;
  localparam int unsigned DIV_BITS   = PCOUNT_BITS + 1;

  localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

  localparam logic [INDEX_BITS-1:0] REG_KEY    = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_PRESC  = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_RELOAD = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_STATUS = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_WINDOW = 3'd4;
  localparam logic [INDEX_BITS-1:0] REG_CAUSE  = 3'd5;

  localparam logic [15:0] KEY_REFRESH = 16'hAAAA;
  localparam logic [15:0] KEY_START   = 16'hCCCC;
  localparam logic [15:0] KEY_UNLOCK  = 16'h5555;

  localparam int unsigned CAUSE_BIT = 26;
  localparam int unsigned CLEAR_BIT = 16;

  localparam logic [CODE_BITS-1:0] CODE_MAX = 3'd6;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [INDEX_BITS-1:0] reg_index;
    logic [DATA_BITS-1:0]  write_data;
  } iwdg_item_t;

  function automatic logic [DIV_BITS-1:0] divider(input logic [CODE_BITS-1:0] code);
    logic [CODE_BITS-1:0] c;
    c = (code > CODE_MAX) ? CODE_MAX : code;
    return DIV_BITS'(9'd4 << c);
  endfunction

endpackage

`default_nettype wire

// File: hdl/iwdg_core.sv
`default_nettype none

module iwdg_core #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire iwdg_pkg::iwdg_item_t          item,
  output logic [iwdg_pkg::DATA_BITS-1:0]     read_data,
  output logic                               fire,
  output logic [COUNT_BITS-1:0]              count_now
);
  import iwdg_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MASK = '1;

  logic [COUNT_BITS-1:0]  down_counter, down_counter_next;
  logic [COUNT_BITS-1:0]  reload_value, reload_value_next;
  logic [COUNT_BITS-1:0]  window_value, window_value_next;
  logic [CODE_BITS-1:0]   prescale_code, prescale_code_next;
  logic [PCOUNT_BITS-1:0] prescale_count, prescale_count_next;
  logic running, running_next;
  logic unlocked, unlocked_next;
  logic prescale_busy, prescale_busy_next;
  logic reload_busy, reload_busy_next;
  logic fired_flag, fired_flag_next;

  always_comb begin
    logic [DIV_BITS-1:0]   sum;
    logic [15:0]           key;
    logic [COUNT_BITS-1:0] dec;
    down_counter_next   = down_counter;
    reload_value_next   = reload_value;
    window_value_next   = window_value;
    prescale_code_next  = prescale_code;
    prescale_count_next = prescale_count;
    running_next        = running;
    unlocked_next       = unlocked;
    prescale_busy_next  = prescale_busy;
    reload_busy_next    = reload_busy;
    fired_flag_next     = fired_flag;
    read_data           = '0;
    fire                = 1'b0;
    sum = DIV_BITS'(prescale_count) + DIV_BITS'(1);
    key = item.write_data[15:0];
    dec = down_counter - COUNT_BITS'(1);
    unique case (item.op)
      OP_TICK: begin
        prescale_busy_next = 1'b0;
        reload_busy_next   = 1'b0;
        if (running) begin
          if (sum >= divider(prescale_code)) begin
            prescale_count_next = '0;
            if (down_counter == '0) begin
              fire = 1'b1;
            end else begin
              down_counter_next = dec;
              if (dec == '0) begin
                fire = 1'b1;
              end
            end
          end else begin
            prescale_count_next = sum[PCOUNT_BITS-1:0];
          end
        end
      end
      OP_WRITE: begin
        unique case (item.reg_index)
          REG_KEY: begin
            if (key == KEY_UNLOCK) begin
              unlocked_next = 1'b1;
            end else begin
              unlocked_next = 1'b0;
              if (key == KEY_REFRESH) begin
                if (running && (down_counter > window_value)) begin
                  fire = 1'b1;
                end else begin
                  down_counter_next   = reload_value;
                  prescale_count_next = '0;
                end
              end else if (key == KEY_START) begin
                running_next = 1'b1;
              end
            end
          end
          REG_PRESC: begin
            if (unlocked && !prescale_busy) begin
              prescale_code_next = item.write_data[CODE_BITS-1:0];
              prescale_busy_next = 1'b1;
            end
          end
          REG_RELOAD: begin
            if (unlocked && !reload_busy) begin
              reload_value_next = item.write_data[COUNT_BITS-1:0];
              reload_busy_next  = 1'b1;
            end
          end
          REG_WINDOW: begin
            if (unlocked) begin
              window_value_next = item.write_data[COUNT_BITS-1:0];
            end
          end
          REG_CAUSE: begin
            if (item.write_data[CLEAR_BIT]) begin
              fired_flag_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      OP_READ: begin
        unique case (item.reg_index)
          REG_PRESC:  read_data = DATA_BITS'(prescale_code);
          REG_RELOAD: read_data = DATA_BITS'(reload_value);
          REG_STATUS: read_data = DATA_BITS'({reload_busy, prescale_busy});
          REG_WINDOW: read_data = DATA_BITS'(window_value);
          REG_CAUSE:  read_data = DATA_BITS'(fired_flag) << CAUSE_BIT;
          default:    read_data = '0;
        endcase
      end
      default: begin
      end
    endcase
    if (fire) begin
      down_counter_next   = COUNT_MASK;
      reload_value_next   = COUNT_MASK;
      window_value_next   = COUNT_MASK;
      prescale_code_next  = '0;
      prescale_count_next = '0;
      running_next        = 1'b0;
      unlocked_next       = 1'b0;
      prescale_busy_next  = 1'b0;
      reload_busy_next    = 1'b0;
      fired_flag_next     = 1'b1;
    end
  end

  assign count_now = down_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_counter   <= COUNT_MASK;
      reload_value   <= COUNT_MASK;
      window_value   <= COUNT_MASK;
      prescale_code  <= '0;
      prescale_count <= '0;
      running        <= 1'b0;
      unlocked       <= 1'b0;
      prescale_busy  <= 1'b0;
      reload_busy    <= 1'b0;
      fired_flag     <= 1'b0;
    end else if (accept) begin
      down_counter   <= down_counter_next;
      reload_value   <= reload_value_next;
      window_value   <= window_value_next;
      prescale_code  <= prescale_code_next;
      prescale_count <= prescale_count_next;
      running        <= running_next;
      unlocked       <= unlocked_next;
      prescale_busy  <= prescale_busy_next;
      reload_busy    <= reload_busy_next;
      fired_flag     <= fired_flag_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/iwdg_out_reg.sv
`default_nettype none

module iwdg_out_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [WIDTH-1:0]      out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             in_fire;
  logic             out_free;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/independent_watchdog_with_keys.sv
// Each accepted result is registered in the output stage (via the skid entry when stalled).
// Throughput: one transaction per cycle unless stalled; state updates in the accepting cycle.
// A two-entry output stage lets input proceed while a result waits; input stalls only when
// both entries are full.
// Reset (rst, synchronous) restores all registers to their idle values and clears the
// reset-cause flag; a fired watchdog reset restores everything except that flag.
`default_nettype none

module independent_watchdog_with_keys #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [iwdg_pkg::OP_BITS-1:0]   op,
  input  wire logic [iwdg_pkg::INDEX_BITS-1:0] reg_index,
  input  wire logic [iwdg_pkg::DATA_BITS-1:0] write_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [iwdg_pkg::DATA_BITS-1:0]      read_data,
  output logic                                watchdog_reset,
  output logic [COUNT_BITS-1:0]               count_now
);
  import iwdg_pkg::*;

  localparam int unsigned RES_BITS = DATA_BITS + 1 + COUNT_BITS;

  iwdg_item_t            item;
  logic                  accept;
  logic [DATA_BITS-1:0]  core_read_data;
  logic                  core_fire;
  logic [COUNT_BITS-1:0] core_count;
  logic [RES_BITS-1:0]   res_in;
  logic [RES_BITS-1:0]   res_out;

  assign item.op         = op;
  assign item.reg_index  = reg_index;
  assign item.write_data = write_data;
  assign accept          = in_valid && !in_stall;

  iwdg_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .read_data (core_read_data),
    .fire      (core_fire),
    .count_now (core_count)
  );

  assign res_in = {core_read_data, core_fire, core_count};

  iwdg_out_reg #(
    .WIDTH(RES_BITS)
  ) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (res_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign read_data      = res_out[RES_BITS-1 -: DATA_BITS];
  assign watchdog_reset = res_out[COUNT_BITS];
  assign count_now      = res_out[COUNT_BITS-1:0];

endmodule

`default_nettype wire

// File: hdl/iwdg_checker.sv
`default_nettype none

module iwdg_checker #(
  parameter int unsigned COUNT_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [31:0]           read_data,
  input wire logic                  watchdog_reset,
  input wire logic [COUNT_BITS-1:0] count_now
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(watchdog_reset)
      && $stable(count_now))
    else $error("stalled result changed");

  // A fired reset leaves the counter at its idle value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && watchdog_reset |-> count_now == {COUNT_BITS{1'b1}})
    else $error("counter not idle after watchdog reset");

  // Read data carries only register bits or the reset-cause bit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_data[31:27] == 5'd0 && read_data[25:16] == 10'd0)
    else $error("unexpected read data bits");

  // Input is stalled only while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // No result is presented straight after reset.
  assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind independent_watchdog_with_keys iwdg_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_iwdg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_data      (read_data),
  .watchdog_reset (watchdog_reset),
  .count_now      (count_now)
);

`default_nettype wire
